[rtl/core/arpc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types and constants for the aging page cache tag block
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int PAGE_W  = 20;
    localparam int INDEX_W = 4;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [INDEX_W-1:0] t_index;

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_AGE    = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic hit;
        logic free_found;
    } t_scan_flags;

endpackage
`default_nettype wire

[rtl/core/aging_replacement_page_cache_tags.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aging_replacement_page_cache_tags
// tag and aging replacement side of a fully associative page cache
// lookup: result word loaded once the sweep of all entries ends, and held off
//   while an earlier word waits on i_stall; next word taken the cycle after
// age tick: one-entry-a-cycle memory sweep, then the referenced flops clear
// reset clears valid and referenced flops at once; memories are not cleared
// ----------------------------------------------------------------------------
module aging_replacement_page_cache_tags import arpc_pkg::*; #(
    parameter int ENTRIES   = 16,
    parameter int AGE_BITS  = 32,
    parameter int PAGE_BITS = 20,
    localparam int IDX_W    = $clog2(ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_req_type,
    input  logic [PAGE_BITS-1:0] i_page_number,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_hit,
    output logic [IDX_W-1:0]     o_entry_index,
    output logic                 o_evicted,
    output logic [PAGE_BITS-1:0] o_evicted_page
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

    typedef logic [PAGE_BITS-1:0] t_tag;

    t_state r_state;
    t_state n_state;

    logic [PAGE_BITS-1:0] tag_mem [ENTRIES];
    logic [AGE_BITS-1:0]  age_mem [ENTRIES];

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_chk;
    logic [IDX_W-1:0]     r_chk_idx;
    logic [PAGE_BITS-1:0] r_tag_q;
    logic [AGE_BITS-1:0]  r_age_q;
    t_tag                 r_page;
    logic [ENTRIES-1:0]   r_valid;
    logic [ENTRIES-1:0]   r_ref;

    logic             r_out_valid;
    logic             r_hit;
    logic [IDX_W-1:0] r_entry_index;
    logic             r_evicted;
    t_tag             r_evicted_page;

    logic                 in_acc;
    logic                 rd_en;
    logic                 commit;
    logic                 age_wr;
    logic                 ref_clr;
    logic                 scan_chk;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic                 tag_we;
    logic                 age_we;
    logic [AGE_BITS-1:0]  age_wdata;
    t_scan_flags          scan_flags;
    logic [IDX_W-1:0]     scan_chosen;
    logic [PAGE_BITS-1:0] scan_best_tag;

    assign in_acc  = i_valid && !o_stall;
    assign rd_addr = r_cnt[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (t_req'(i_req_type) == REQ_AGE) ? ST_AGE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CNT_END) begin
                    n_state = ST_RESULT;
                end
            end
            ST_AGE: begin
                if (r_cnt == CNT_END) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESULT: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall  = 1'b1;
        rd_en    = 1'b0;
        commit   = 1'b0;
        age_wr   = 1'b0;
        ref_clr  = 1'b0;
        scan_chk = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
            end
            ST_SCAN: begin
                rd_en    = (r_cnt != CNT_END);
                scan_chk = r_chk;
            end
            ST_AGE: begin
                rd_en   = (r_cnt != CNT_END);
                age_wr  = r_chk && r_valid[r_chk_idx];
                ref_clr = (r_cnt == CNT_END);
            end
            ST_RESULT: begin
                commit = !r_out_valid || !i_stall;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cnt  <= '0;
            r_page <= i_page_number;
        end else if (rd_en) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_chk_idx <= rd_addr;
    end

    // entry memories
    assign wr_addr   = (r_state == ST_AGE) ? r_chk_idx : scan_chosen;
    assign tag_we    = commit && !scan_flags.hit;
    assign age_we    = age_wr || (commit && !scan_flags.hit && scan_flags.free_found);
    assign age_wdata = (r_state == ST_AGE) ? {r_ref[r_chk_idx], r_age_q[AGE_BITS-1:1]}
                                           : '0;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_tag_q <= tag_mem[rd_addr];
            r_age_q <= age_mem[rd_addr];
        end
        if (tag_we) begin
            tag_mem[wr_addr] <= r_page;
        end
        if (age_we) begin
            age_mem[wr_addr] <= age_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ref   <= '0;
        end else begin
            if (ref_clr) begin
                r_ref <= '0;
            end
            if (commit) begin
                r_ref[scan_chosen] <= 1'b1;
                if (!scan_flags.hit) begin
                    r_valid[scan_chosen] <= 1'b1;
                end
            end
        end
    end

    arpc_scan #(
        .ENTRIES   (ENTRIES),
        .AGE_BITS  (AGE_BITS),
        .PAGE_BITS (PAGE_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc),
        .i_chk       (scan_chk),
        .i_chk_idx   (r_chk_idx),
        .i_chk_valid (r_valid[r_chk_idx]),
        .i_chk_tag   (r_tag_q),
        .i_chk_age   (r_age_q),
        .i_page      (r_page),
        .o_flags     (scan_flags),
        .o_chosen    (scan_chosen),
        .o_best_tag  (scan_best_tag)
    );

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hit         <= scan_flags.hit;
            r_entry_index <= scan_chosen;
            r_evicted     <= !scan_flags.hit && !scan_flags.free_found;
            if (!scan_flags.hit && !scan_flags.free_found) begin
                r_evicted_page <= scan_best_tag;
            end else begin
                r_evicted_page <= '0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_hit          = r_hit;
    assign o_entry_index  = r_entry_index;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_evicted_page;

    a_fill_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && !scan_flags.hit |=> r_valid[$past(scan_chosen)])
        else $error("filled entry not marked valid");

    a_valid_never_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> $countones(r_valid) >= $countones($past(r_valid)))
        else $error("valid entry lost");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_SCAN || r_state == ST_AGE))
        else $error("accepted word not processed");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(commit))
        else $error("result word without lookup");

    a_age_clears_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_AGE && r_cnt == CNT_END |=> r_ref == '0)
        else $error("referenced bits left after age sweep");

endmodule
`default_nettype wire

[rtl/core/arpc_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_scan
// walks the entry words read from the tag and age memories, one per cycle,
// and keeps the hit, the first free entry and the oldest valid entry
// ----------------------------------------------------------------------------
module arpc_scan import arpc_pkg::*; #(
    parameter int ENTRIES   = 16,
    parameter int AGE_BITS  = 32,
    parameter int PAGE_BITS = 20,
    localparam int IDX_W    = $clog2(ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_chk,
    input  logic [IDX_W-1:0]     i_chk_idx,
    input  logic                 i_chk_valid,
    input  logic [PAGE_BITS-1:0] i_chk_tag,
    input  logic [AGE_BITS-1:0]  i_chk_age,
    input  logic [PAGE_BITS-1:0] i_page,
    output t_scan_flags          o_flags,
    output logic [IDX_W-1:0]     o_chosen,
    output logic [PAGE_BITS-1:0] o_best_tag
);

    t_scan_flags          r_flags;
    logic                 r_have_best;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [IDX_W-1:0]     r_free_idx;
    logic [IDX_W-1:0]     r_best_idx;
    logic [PAGE_BITS-1:0] r_best_tag;
    logic [AGE_BITS-1:0]  r_best_age;

    logic is_hit;
    logic is_free;
    logic is_older;

    assign is_hit   = i_chk && !r_flags.hit && i_chk_valid && (i_chk_tag == i_page);
    assign is_free  = i_chk && !r_flags.free_found && !i_chk_valid;
    assign is_older = i_chk && !r_flags.free_found && i_chk_valid
                      && (!r_have_best || (i_chk_age < r_best_age));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_have_best <= 1'b0;
        end else if (i_start) begin
            r_flags     <= '0;
            r_have_best <= 1'b0;
        end else begin
            if (is_hit) begin
                r_flags.hit <= 1'b1;
            end
            if (is_free) begin
                r_flags.free_found <= 1'b1;
            end
            if (is_older) begin
                r_have_best <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_hit) begin
            r_hit_idx <= i_chk_idx;
        end
        if (is_free) begin
            r_free_idx <= i_chk_idx;
        end
        if (is_older) begin
            r_best_idx <= i_chk_idx;
            r_best_tag <= i_chk_tag;
            r_best_age <= i_chk_age;
        end
    end

    assign o_flags    = r_flags;
    assign o_chosen   = r_flags.hit ? r_hit_idx : (r_flags.free_found ? r_free_idx : r_best_idx);
    assign o_best_tag = r_best_tag;

endmodule
`default_nettype wire

[tb/tb_aging_replacement_page_cache_tags.sv]
// ----------------------------------------------------------------------------
// tb_aging_replacement_page_cache_tags
// Self-checking bench for the aging page cache tag block. A directed table
// covers the reset state, the page field extremes, hits, misses into free
// entries, eviction and age ticks. Random lookups over a small page pool
// follow, plus a saturation run that drives every counter to all ones.
// Lookup results are compared against the table for typed rows and against
// a cycle-free predictor of the tag store otherwise. Both handshakes idle at
// random in the first two of three phases. The first includes a long receiver
// hold-off, the second a pause of the sender until the results drain.
module tb_aging_replacement_page_cache_tags;
    import arpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES     = 16;
    localparam int AGE_BITS    = 32;
    localparam int PAGE_BITS   = 20;
    localparam int POOL_SIZE   = 20;
    localparam int DIR_ROWS    = 25;
    localparam int HOLD_CYCLES = 400;
    localparam int STUCK_LIMIT = 3000;
    localparam int TAIL_CYCLES = 4 * (ENTRIES + 3);

    typedef struct packed {
        logic   hit;
        t_index entry_index;
        logic   evicted;
        t_page  evicted_page;
    } t_lookup_res;

    typedef struct packed {
        t_req        req;
        t_page       page;
        logic        typed;
        t_lookup_res res;
    } t_stim_row;

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    logic   i_req_type    = 1'b0;
    t_page  i_page_number = '0;
    logic   i_stall       = 1'b0;
    logic   o_stall;
    logic   o_valid;
    logic   o_hit;
    t_index o_entry_index;
    logic   o_evicted;
    t_page  o_evicted_page;

    aging_replacement_page_cache_tags #(
        .ENTRIES  (ENTRIES),
        .AGE_BITS (AGE_BITS),
        .PAGE_BITS(PAGE_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_page_number (i_page_number),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_entry_index (o_entry_index),
        .o_evicted     (o_evicted),
        .o_evicted_page(o_evicted_page)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted tag store
    t_page               cache_tag   [ENTRIES];
    logic                cache_valid [ENTRIES];
    logic                cache_ref   [ENTRIES];
    logic [AGE_BITS-1:0] cache_age   [ENTRIES];

    t_lookup_res pending_results[$];
    t_lookup_res seen_res;
    t_page       page_pool[POOL_SIZE];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int stuck_cycles  = 0;
    int error_count   = 0;
    int results_seen  = 0;
    int n_lookups     = 0;
    int n_hits        = 0;
    int n_evictions   = 0;
    int n_full_victim = 0;
    int n_ages        = 0;

    t_stim_row directed_rows[DIR_ROWS] = '{
        '{REQ_LOOKUP, 20'h00000, 1'b1, '{1'b0, 4'd0,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h00000, 1'b1, '{1'b1, 4'd0,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'hFFFFF, 1'b1, '{1'b0, 4'd1,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'hFFFFF, 1'b1, '{1'b1, 4'd1,  1'b0, 20'h0}},
        '{REQ_AGE,    20'hFFFFF, 1'b0, '0},
        '{REQ_AGE,    20'h55555, 1'b0, '0},
        '{REQ_LOOKUP, 20'h00000, 1'b1, '{1'b1, 4'd0,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h80000, 1'b1, '{1'b0, 4'd2,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h00001, 1'b1, '{1'b0, 4'd3,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h7FFFF, 1'b1, '{1'b0, 4'd4,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'hAAAAA, 1'b1, '{1'b0, 4'd5,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h55555, 1'b1, '{1'b0, 4'd6,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h12345, 1'b1, '{1'b0, 4'd7,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'hFEDCB, 1'b1, '{1'b0, 4'd8,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h00010, 1'b1, '{1'b0, 4'd9,  1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h00100, 1'b1, '{1'b0, 4'd10, 1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h01000, 1'b1, '{1'b0, 4'd11, 1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h10000, 1'b1, '{1'b0, 4'd12, 1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'hF0F0F, 1'b1, '{1'b0, 4'd13, 1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h0F0F0, 1'b1, '{1'b0, 4'd14, 1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'h3C3C3, 1'b1, '{1'b0, 4'd15, 1'b0, 20'h0}},
        '{REQ_LOOKUP, 20'hC0000, 1'b0, '0},
        '{REQ_AGE,    20'h00000, 1'b0, '0},
        '{REQ_LOOKUP, 20'h80000, 1'b0, '0},
        '{REQ_LOOKUP, 20'hC0000, 1'b0, '0}
    };

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_result(input t_lookup_res got, input t_lookup_res want);
        if (got.hit !== want.hit)
            report_error($sformatf("hit got %0d want %0d", got.hit, want.hit));
        if (got.entry_index !== want.entry_index)
            report_error($sformatf("entry_index got %0d want %0d",
                                   got.entry_index, want.entry_index));
        if (got.evicted !== want.evicted)
            report_error($sformatf("evicted got %0d want %0d", got.evicted, want.evicted));
        if (got.evicted_page !== want.evicted_page)
            report_error($sformatf("evicted_page got %h want %h",
                                   got.evicted_page, want.evicted_page));
    endtask

    task automatic reset_tag_store();
        for (int e = 0; e < ENTRIES; e++) begin
            cache_tag[e]   = '0;
            cache_valid[e] = 1'b0;
            cache_ref[e]   = 1'b0;
            cache_age[e]   = '0;
        end
    endtask

    task automatic apply_word(input t_req req, input t_page page,
                              output logic has_res, output t_lookup_res res);
        int hit_idx;
        int free_idx;
        int victim;
        int chosen;
        hit_idx  = -1;
        free_idx = -1;
        victim   = 0;
        res      = '0;
        has_res  = 1'b0;
        if (req == REQ_AGE) begin
            for (int e = 0; e < ENTRIES; e++) begin
                cache_age[e] = {cache_ref[e], cache_age[e][AGE_BITS-1:1]};
                cache_ref[e] = 1'b0;
            end
            n_ages++;
            return;
        end
        has_res = 1'b1;
        n_lookups++;
        for (int e = ENTRIES - 1; e >= 0; e--)
            if (cache_valid[e] && cache_tag[e] == page)
                hit_idx = e;
        if (hit_idx >= 0) begin
            cache_ref[hit_idx] = 1'b1;
            res.hit            = 1'b1;
            res.entry_index    = t_index'(hit_idx);
            n_hits++;
            return;
        end
        for (int e = 0; e < ENTRIES; e++) begin
            if (free_idx < 0 && !cache_valid[e])
                free_idx = e;
            if (cache_age[e] < cache_age[victim])
                victim = e;
        end
        chosen          = (free_idx >= 0) ? free_idx : victim;
        res.entry_index = t_index'(chosen);
        if (free_idx < 0) begin
            res.evicted      = 1'b1;
            res.evicted_page = cache_tag[chosen];
            n_evictions++;
            if (cache_age[chosen] == '1)
                n_full_victim++;
        end
        cache_tag[chosen]   = page;
        cache_valid[chosen] = 1'b1;
        cache_ref[chosen]   = 1'b1;
    endtask

    task automatic send_word(input t_req req, input t_page page,
                             input logic typed, input t_lookup_res typed_res);
        logic        has_res;
        t_lookup_res predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_page_number <= page;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        apply_word(req, page, has_res, predicted);
        if (has_res)
            pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic refill_pool();
        for (int k = 0; k < POOL_SIZE; k++)
            page_pool[k] = t_page'($urandom);
    endtask

    task automatic run_mix(input int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 12)
                send_word(REQ_AGE, t_page'($urandom), 1'b0, '0);
            else if (roll < 80)
                send_word(REQ_LOOKUP, page_pool[$urandom_range(POOL_SIZE - 1)], 1'b0, '0);
            else
                send_word(REQ_LOOKUP, t_page'($urandom), 1'b0, '0);
        end
    endtask

    // touch every entry before each tick so that all counters end up all ones
    task automatic run_saturation();
        for (int round = 0; round < AGE_BITS; round++) begin
            for (int e = 0; e < ENTRIES; e++)
                send_word(REQ_LOOKUP, cache_valid[e] ? cache_tag[e] : t_page'($urandom),
                          1'b0, '0);
            send_word(REQ_AGE, t_page'($urandom), 1'b0, '0);
        end
        send_word(REQ_LOOKUP, t_page'($urandom), 1'b0, '0);
        send_word(REQ_LOOKUP, t_page'($urandom), 1'b0, '0);
    endtask

    // receiver: checks each result word and drives stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_res = {o_hit, o_entry_index, o_evicted, o_evicted_page};
            results_seen++;
            if (pending_results.size() == 0)
                report_error("result word with no lookup outstanding");
            else
                check_result(seen_res, pending_results.pop_front());
        end
        if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_stall     <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", stuck_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        reset_tag_store();
        refill_pool();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct <= 71;
        for (int r = 0; r < DIR_ROWS; r++)
            send_word(directed_rows[r].req, directed_rows[r].page,
                      directed_rows[r].typed, directed_rows[r].res);
        run_mix(150);
        hold_asked <= hold_asked + 1;
        run_mix(150);

        send_idle_pct = 71;
        recv_idle_pct <= 9;
        refill_pool();
        run_mix(100);
        wait_for_drain();
        run_mix(100);

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        refill_pool();
        run_saturation();
        run_mix(80);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_error("lookups left without a result word");

        $display("covered %0d lookups (%0d hits, %0d evictions, %0d of all-ones victims)",
                 n_lookups, n_hits, n_evictions, n_full_victim);
        $display("and %0d age ticks; %0d result words checked, %0d mismatches",
                 n_ages, results_seen, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
